// ===== rtl/core/uce_pkg.sv =====
// Package for the EP0 request handler: request codes, op classes and the
// classified-item struct passed from front to back. No dependencies.
`default_nettype none
package uce_pkg;

	localparam int unsigned PacketSizeDefault = 8;
	localparam logic [6:0] LineCodingBytes = 7'd7;
	localparam logic [7:0] NoRequest = 8'hFF;
	localparam logic [2:0] NoDesc = 3'd7;

	// event kinds on tuser
	localparam logic [1:0] CmdSetup = 2'd0;
	localparam logic [1:0] CmdIn = 2'd1;
	localparam logic [1:0] CmdOut = 2'd2;

	// request codes
	localparam logic [7:0] ReqGetStatus = 8'h00;
	localparam logic [7:0] ReqClrFeature = 8'h01;
	localparam logic [7:0] ReqSetFeature = 8'h03;
	localparam logic [7:0] ReqSetAddress = 8'h05;
	localparam logic [7:0] ReqGetDesc = 8'h06;
	localparam logic [7:0] ReqGetConfig = 8'h08;
	localparam logic [7:0] ReqSetConfig = 8'h09;
	localparam logic [7:0] ReqGetIface = 8'h0A;
	localparam logic [7:0] ReqSetIface = 8'h0B;
	localparam logic [7:0] ReqSetLineCoding = 8'h20;
	localparam logic [7:0] ReqGetLineCoding = 8'h21;
	localparam logic [7:0] ReqSetCtrlLine = 8'h22;

	// handshakes, sources, class events
	localparam logic [1:0] HsAck = 2'd0;
	localparam logic [1:0] HsStall = 2'd1;
	localparam logic [1:0] HsNak = 2'd2;
	localparam logic [2:0] SrcNone = 3'd0;
	localparam logic [2:0] SrcDesc = 3'd1;
	localparam logic [2:0] SrcConfig = 3'd2;
	localparam logic [2:0] SrcStatus = 3'd3;
	localparam logic [2:0] SrcClass = 3'd4;
	localparam logic [1:0] EvNone = 2'd0;
	localparam logic [1:0] EvGetLine = 2'd1;
	localparam logic [1:0] EvSetCtrl = 2'd2;
	localparam logic [1:0] EvLineData = 2'd3;

	// register indexes
	localparam logic [2:0] RegWakeup = 3'd7;

	typedef enum logic [3:0] {
		OP_STALL,
		OP_SIMPLE,
		OP_GETDESC,
		OP_SETADDR,
		OP_SETCFG,
		OP_CLRHALT,
		OP_SETHALT,
		OP_DEVFEAT,
		OP_IN,
		OP_OUT,
		OP_BUSRESET
	} op_t;

	typedef struct packed {
		op_t op;
		logic [7:0] code;
		logic [15:0] length;
		logic [6:0] tx;
		logic [2:0] src;
		logic [1:0] ev;
		logic [2:0] dsel;
		logic [2:0] halt_bit;
		logic [7:0] value_lo;
		logic flag;
	} item_t;

endpackage
`default_nettype wire

// ===== rtl/core/usb_control_endpoint_request_handler_core.sv =====
// EP0 request handler top level: front classifier, item queue, back executor.
// An accepted beat is written into the item queue, then executed into the result register on m_tdata.
// Throughput: one item per cycle from the back executor while the result register is not stalled.
// Up to two items wait in the queue while the result register is stalled.
// Reset (arst_n low) clears transfer state and restores register defaults.
`default_nettype none
module usb_control_endpoint_request_handler_core #(
	parameter int unsigned EP0_PACKET_SIZE = uce_pkg::PacketSizeDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// [7:0] request_type, [15:8] request_code, [31:16] request_value,
	// [47:32] request_index, [63:48] request_length, [64] out_toggle_ok
	input wire logic [71:0] s_tdata,
	// [1:0] cmd
	input wire logic [1:0] s_tuser,
	output logic m_tvalid,
	input wire logic m_tready,
	// [1:0] handshake, [8:2] tx_len, [11:9] data_source, [14:12] desc_select,
	// [22:15] desc_offset, [30:23] config_value, [37:31] device_address,
	// [45:38] endpoint_halts, [47:46] class_event
	output logic [47:0] m_tdata,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [7:0] cfg_data
);
	import uce_pkg::*;

	item_t front_item, head_item;
	logic q_full, head_valid, exec, push;

	assign cfg_ready = 1'b1;
	assign s_tready = !q_full;
	assign push = s_tvalid && !q_full;
	assign exec = head_valid && (!m_tvalid || m_tready);

	uce_front u_front (
		.cmd(s_tuser),
		.request_type(s_tdata[7:0]),
		.request_code(s_tdata[15:8]),
		.request_value(s_tdata[31:16]),
		.request_index(s_tdata[47:32]),
		.request_length(s_tdata[63:48]),
		.out_toggle_ok(s_tdata[64]),
		.item(front_item)
	);

	uce_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(front_item),
		.full(q_full),
		.pop(exec),
		.head_valid(head_valid),
		.head_item(head_item)
	);

	uce_back #(
		.EP0_PACKET_SIZE(EP0_PACKET_SIZE)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.exec(exec),
		.it(head_item),
		.out_valid(m_tvalid),
		.out_take(m_tready),
		.out_data(m_tdata)
	);
endmodule
`default_nettype wire

// ===== rtl/core/uce_front.sv =====
// Front part: takes input beats and classifies each into an item_t.
// Depends on uce_pkg.
`default_nettype none
module uce_front (
	input wire logic [1:0] cmd,
	input wire logic [7:0] request_type,
	input wire logic [7:0] request_code,
	input wire logic [15:0] request_value,
	input wire logic [15:0] request_index,
	input wire logic [15:0] request_length,
	input wire logic out_toggle_ok,
	output uce_pkg::item_t item
);
	import uce_pkg::*;

	logic [1:0] kind;
	logic [4:0] recip;
	logic clr_ok, set_ok;
	logic [2:0] clr_bit, set_bit;
	logic [2:0] ep_m1;
	logic [7:0] sidx;

	assign kind = request_type[6:5];
	assign recip = request_type[4:0];
	assign sidx = request_value[7:0];

	// endpoint address to halt bit
	always_comb begin
		clr_ok = ((request_index[7:0] & 8'h78) == 8'h00) &&
			(request_index[2:0] >= 3'd1) && (request_index[2:0] <= 3'd4);
		set_ok = ((request_index & 16'hFF78) == 16'h0000) &&
			(request_index[2:0] >= 3'd1) && (request_index[2:0] <= 3'd4);
		ep_m1 = request_index[2:0] - 3'd1;
		clr_bit = {ep_m1[1:0], request_index[7]};
		set_bit = clr_bit;
	end

	// classify
	always_comb begin
		item = '0;
		item.op = OP_SIMPLE;
		item.code = request_code;
		item.length = request_length;
		item.src = SrcNone;
		item.ev = EvNone;
		item.dsel = NoDesc;
		item.value_lo = request_value[7:0];
		item.flag = out_toggle_ok;
		case (cmd)
			CmdSetup: begin
				if (kind == 2'd1) begin
					case (request_code)
						ReqGetLineCoding: begin
							item.tx = (request_length < 16'(LineCodingBytes)) ?
								request_length[6:0] : LineCodingBytes;
							item.src = SrcClass;
							item.ev = EvGetLine;
						end
						ReqSetCtrlLine: item.ev = EvSetCtrl;
						ReqSetLineCoding: ;
						default: item.op = OP_STALL;
					endcase
				end else if (kind != 2'd0) begin
					item.op = OP_STALL;
				end else begin
					case (request_code)
						ReqGetDesc: begin
							item.op = OP_GETDESC;
							case (request_value[15:8])
								8'd1: item.dsel = 3'd0;
								8'd2: item.dsel = 3'd1;
								8'd3: item.dsel = (sidx <= 8'd4) ? 3'd2 + sidx[2:0] : 3'd5;
								default: item.op = OP_STALL;
							endcase
						end
						ReqSetAddress: item.op = OP_SETADDR;
						ReqGetConfig: begin
							item.tx = (request_length != 16'd0) ? 7'd1 : 7'd0;
							item.src = SrcConfig;
						end
						ReqSetConfig: item.op = OP_SETCFG;
						ReqGetIface, ReqSetIface: ;
						ReqClrFeature: begin
							item.halt_bit = clr_bit;
							if (recip == 5'd0) begin
								item.op = OP_DEVFEAT;
								item.flag = (request_value == 16'd1);
							end else if (recip == 5'd2 && clr_ok) begin
								item.op = OP_CLRHALT;
							end else begin
								item.op = OP_STALL;
							end
						end
						ReqSetFeature: begin
							item.halt_bit = set_bit;
							if (recip == 5'd0) begin
								item.op = OP_DEVFEAT;
								item.flag = (request_value == 16'd1);
							end else if (recip == 5'd2 && request_value == 16'd0 && set_ok) begin
								item.op = OP_SETHALT;
							end else begin
								item.op = OP_STALL;
							end
						end
						ReqGetStatus: begin
							item.tx = (request_length < 16'd2) ? request_length[6:0] : 7'd2;
							item.src = SrcStatus;
						end
						default: item.op = OP_STALL;
					endcase
				end
			end
			CmdIn: item.op = OP_IN;
			CmdOut: item.op = OP_OUT;
			default: item.op = OP_BUSRESET;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/core/uce_queue.sv =====
// Two-entry queue of classified items between front and back.
// Depends on uce_pkg.
`default_nettype none
module uce_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire uce_pkg::item_t push_item,
	output logic full,
	input wire logic pop,
	output logic head_valid,
	output uce_pkg::item_t head_item
);
	import uce_pkg::*;

	item_t mem_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_item = mem_q[rd_ptr_q];

	// store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/uce_back.sv =====
// Back part: holds control-transfer state and config registers, executes
// items and registers one result beat. Depends on uce_pkg.
`default_nettype none
module uce_back #(
	parameter int unsigned EP0_PACKET_SIZE = uce_pkg::PacketSizeDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	input wire logic [2:0] cfg_index,
	input wire logic [7:0] cfg_data,
	input wire logic exec,
	input wire uce_pkg::item_t it,
	output logic out_valid,
	input wire logic out_take,
	output logic [47:0] out_data
);
	import uce_pkg::*;

	localparam logic [15:0] PktLen = 16'(EP0_PACKET_SIZE);

	logic [7:0] regs_q [8];
	logic [7:0] pending_q;
	logic [15:0] bytes_q;
	logic [2:0] cur_desc_q;
	logic [7:0] cur_off_q;
	logic [6:0] pend_addr_q, addr_q;
	logic [7:0] cfg_val_q, halts_q;
	logic out_valid_q;
	logic [47:0] out_data_q;

	logic [15:0] chunk_base, new_bytes;
	logic [6:0] chunk;
	logic [1:0] hs;
	logic [6:0] tx;
	logic [2:0] src, dsel;
	logic [7:0] doff;
	logic [1:0] ev;
	logic stall;
	logic [7:0] nxt_pending, nxt_cfg, nxt_halts, nxt_off;
	logic [15:0] nxt_bytes;
	logic [2:0] nxt_desc;
	logic [6:0] nxt_paddr, nxt_addr;

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	// execute one item
	always_comb begin
		nxt_pending = pending_q;
		nxt_bytes = bytes_q;
		nxt_desc = cur_desc_q;
		nxt_off = cur_off_q;
		nxt_paddr = pend_addr_q;
		nxt_cfg = cfg_val_q;
		nxt_addr = addr_q;
		nxt_halts = halts_q;
		hs = HsNak;
		tx = 7'd0;
		src = SrcNone;
		dsel = NoDesc;
		doff = 8'd0;
		ev = EvNone;
		stall = 1'b0;
		chunk_base = bytes_q;
		if (it.op == OP_GETDESC) begin
			chunk_base = (it.length < {8'd0, regs_q[it.dsel]}) ?
				it.length : {8'd0, regs_q[it.dsel]};
		end
		chunk = (chunk_base < PktLen) ? chunk_base[6:0] : PktLen[6:0];
		new_bytes = chunk_base - {9'd0, chunk};
		case (it.op)
			OP_IN: begin
				if (pending_q == ReqGetDesc) begin
					hs = HsAck;
					src = SrcDesc;
					dsel = cur_desc_q;
					doff = cur_off_q;
					tx = chunk;
					nxt_bytes = new_bytes;
					nxt_off = cur_off_q + {1'b0, chunk};
				end else if (pending_q == ReqSetAddress) begin
					nxt_addr = pend_addr_q;
				end
			end
			OP_OUT: begin
				if (pending_q == ReqSetLineCoding && it.flag) begin
					hs = HsAck;
					ev = EvLineData;
				end
			end
			OP_BUSRESET: begin
				nxt_pending = NoRequest;
				nxt_bytes = 16'd0;
				nxt_desc = NoDesc;
				nxt_off = 8'd0;
				nxt_paddr = 7'd0;
				nxt_cfg = 8'd0;
				nxt_addr = 7'd0;
				nxt_halts = 8'd0;
			end
			default: begin
				// setup packet
				nxt_pending = it.code;
				nxt_bytes = it.length;
				hs = HsAck;
				tx = it.tx;
				src = it.src;
				ev = it.ev;
				case (it.op)
					OP_STALL: stall = 1'b1;
					OP_GETDESC: begin
						nxt_desc = it.dsel;
						src = SrcDesc;
						dsel = it.dsel;
						tx = chunk;
						nxt_bytes = new_bytes;
						nxt_off = {1'b0, chunk};
					end
					OP_SETADDR: nxt_paddr = it.value_lo[6:0];
					OP_SETCFG: nxt_cfg = it.value_lo;
					OP_CLRHALT: nxt_halts = halts_q & ~(8'd1 << it.halt_bit);
					OP_SETHALT: nxt_halts = halts_q | (8'd1 << it.halt_bit);
					OP_DEVFEAT: stall = !(it.flag && regs_q[RegWakeup][0]);
					default: ;
				endcase
				if (stall) begin
					nxt_pending = NoRequest;
					hs = HsStall;
					tx = 7'd0;
					src = SrcNone;
					dsel = NoDesc;
					doff = 8'd0;
					ev = EvNone;
				end
			end
		endcase
	end

	// hold config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[0] <= 8'd18;
			regs_q[1] <= 8'd67;
			regs_q[2] <= 8'd4;
			regs_q[3] <= 8'd0;
			regs_q[4] <= 8'd0;
			regs_q[5] <= 8'd0;
			regs_q[6] <= 8'd0;
			regs_q[7] <= 8'd0;
		end else if (cfg_valid) begin
			regs_q[cfg_index] <= (cfg_index == RegWakeup) ? {7'd0, cfg_data[0]} : cfg_data;
		end
	end

	// update transfer state and output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= NoRequest;
			bytes_q <= 16'd0;
			cur_desc_q <= NoDesc;
			cur_off_q <= 8'd0;
			pend_addr_q <= 7'd0;
			cfg_val_q <= 8'd0;
			addr_q <= 7'd0;
			halts_q <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (exec) begin
				pending_q <= nxt_pending;
				bytes_q <= nxt_bytes;
				cur_desc_q <= nxt_desc;
				cur_off_q <= nxt_off;
				pend_addr_q <= nxt_paddr;
				cfg_val_q <= nxt_cfg;
				addr_q <= nxt_addr;
				halts_q <= nxt_halts;
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (exec) begin
			out_data_q <= {ev, nxt_halts, nxt_addr, nxt_cfg, doff, dsel, src, tx, hs};
		end
	end
endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the EP0 request handler core: directed table, then random
// setup/token sequences under several register settings, checked against a local predictor.
// Depends on uce_pkg and usb_control_endpoint_request_handler_core.
`default_nettype none
module testbench;
	import uce_pkg::*;

	localparam int unsigned PktSize = 8;
	localparam logic [1:0] CmdBusReset = 2'd3;
	localparam logic [1:0] TypeStd = 2'd0;
	localparam logic [1:0] TypeClass = 2'd1;
	localparam logic [4:0] RcpDevice = 5'd0;
	localparam logic [4:0] RcpEndpoint = 5'd2;
	localparam logic [7:0] DtDevice = 8'd1;
	localparam logic [7:0] DtConfig = 8'd2;
	localparam logic [7:0] DtString = 8'd3;
	localparam logic [15:0] FeatWakeup = 16'd1;
	localparam logic [7:0] RtStdDev = 8'h00;
	localparam logic [7:0] RtStdEp = 8'h02;
	localparam logic [7:0] RtClass = 8'h21;
	localparam logic [7:0] RtVendor = 8'h40;
	localparam logic [7:0] RtReserved = 8'h60;
	localparam logic [7:0] ReqUnknown = 8'h07;
	localparam int NumRegs = 8;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] rtype;
		logic [7:0] code;
		logic [15:0] value;
		logic [15:0] index;
		logic [15:0] length;
		logic tog;
	} event_t;

	// packed to match m_tdata, class_event in the top bits
	typedef struct packed {
		logic [1:0] ev;
		logic [7:0] halts;
		logic [6:0] addr;
		logic [7:0] cfg;
		logic [7:0] off;
		logic [2:0] dsel;
		logic [2:0] src;
		logic [6:0] tx;
		logic [1:0] hs;
	} answer_t;

	typedef struct packed {
		event_t ev;
		logic known;
		logic [1:0] hs;
		logic [6:0] tx;
	} row_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready, cfg_valid, cfg_ready;
	logic [71:0] s_tdata;
	logic [1:0] s_tuser;
	logic [47:0] m_tdata;
	logic [2:0] cfg_index;
	logic [7:0] cfg_data;

	usb_control_endpoint_request_handler_core #(.EP0_PACKET_SIZE(PktSize)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow of the block's registers and transfer state
	logic [7:0] desc_len [0:6];
	logic wake_ok;
	logic [7:0] pend_req;
	logic [15:0] remain;
	logic [2:0] cur_desc;
	logic [7:0] cur_off;
	logic [6:0] pend_addr;
	logic [7:0] sel_cfg;
	logic [6:0] usb_addr;
	logic [7:0] halts;

	answer_t answers_due[$];
	int errors = 0;
	bit no_idle = 0;
	int rdy_hold = 0;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("testbench failed");
		$finish;
	end

	// halt bit of an endpoint address, -1 when not endpoint 1..4 IN or OUT
	function automatic int halt_bit(logic [15:0] a);
		if ((a & ~16'h0087) != 0 || a[6:0] < 1 || a[6:0] > 4)
			return -1;
		return 2 * (a[6:0] - 1) + a[7];
	endfunction

	function automatic logic [6:0] next_chunk();
		logic [15:0] n;
		n = (remain < 16'(PktSize)) ? remain : 16'(PktSize);
		remain = remain - n;
		cur_off = cur_off + n[7:0];
		return n[6:0];
	endfunction

	function automatic answer_t answer_for(event_t e);
		answer_t a;
		logic stall;
		logic [7:0] sidx;
		int b;
		a = '0;
		a.hs = HsNak;
		a.dsel = NoDesc;
		stall = 0;
		case (e.cmd)
			CmdSetup: begin
				remain = e.length;
				pend_req = e.code;
				a.hs = HsAck;
				if (e.rtype[6:5] == TypeClass) begin
					if (e.code == ReqGetLineCoding) begin
						a.tx = (e.length < LineCodingBytes) ? e.length[6:0] : LineCodingBytes;
						a.src = SrcClass;
						a.ev = EvGetLine;
					end else if (e.code == ReqSetCtrlLine) begin
						a.ev = EvSetCtrl;
					end else if (e.code != ReqSetLineCoding) begin
						stall = 1;
					end
				end else if (e.rtype[6:5] != TypeStd) begin
					stall = 1;
				end else begin
					case (e.code)
						ReqGetDesc: begin
							sidx = e.value[7:0];
							if (e.value[15:8] == DtDevice) cur_desc = 3'd0;
							else if (e.value[15:8] == DtConfig) cur_desc = 3'd1;
							else if (e.value[15:8] == DtString)
								cur_desc = (sidx <= 4) ? 3'd2 + sidx[2:0] : 3'd5;
							else stall = 1;
							if (!stall) begin
								remain = (e.length < desc_len[cur_desc]) ? e.length
									: {8'd0, desc_len[cur_desc]};
								cur_off = 0;
								a.src = SrcDesc;
								a.dsel = cur_desc;
								a.tx = next_chunk();
							end
						end
						ReqSetAddress: pend_addr = e.value[6:0];
						ReqGetConfig: begin
							a.tx = (e.length >= 1) ? 7'd1 : 7'd0;
							a.src = SrcConfig;
						end
						ReqSetConfig: sel_cfg = e.value[7:0];
						ReqGetIface, ReqSetIface: ;
						ReqClrFeature: begin
							if (e.rtype[4:0] == RcpDevice) begin
								stall = !(e.value == FeatWakeup && wake_ok);
							end else if (e.rtype[4:0] == RcpEndpoint) begin
								b = halt_bit({8'd0, e.index[7:0]});
								if (b < 0) stall = 1;
								else halts[b] = 1'b0;
							end else begin
								stall = 1;
							end
						end
						ReqSetFeature: begin
							if (e.rtype[4:0] == RcpDevice) begin
								stall = !(e.value == FeatWakeup && wake_ok);
							end else if (e.rtype[4:0] == RcpEndpoint && e.value == 0) begin
								b = halt_bit(e.index);
								if (b < 0) stall = 1;
								else halts[b] = 1'b1;
							end else begin
								stall = 1;
							end
						end
						ReqGetStatus: begin
							a.tx = (e.length < 2) ? e.length[6:0] : 7'd2;
							a.src = SrcStatus;
						end
						default: stall = 1;
					endcase
				end
				if (stall) begin
					pend_req = NoRequest;
					a = '0;
					a.hs = HsStall;
					a.dsel = NoDesc;
				end
			end
			CmdIn: begin
				if (pend_req == ReqGetDesc) begin
					a.hs = HsAck;
					a.src = SrcDesc;
					a.dsel = cur_desc;
					a.off = cur_off;
					a.tx = next_chunk();
				end else if (pend_req == ReqSetAddress) begin
					usb_addr = pend_addr;
				end
			end
			CmdOut: begin
				if (pend_req == ReqSetLineCoding && e.tog) begin
					a.hs = HsAck;
					a.ev = EvLineData;
				end
			end
			default: begin
				pend_req = NoRequest;
				remain = 0;
				cur_desc = NoDesc;
				cur_off = 0;
				pend_addr = 0;
				sel_cfg = 0;
				usb_addr = 0;
				halts = 0;
			end
		endcase
		a.cfg = sel_cfg;
		a.addr = usb_addr;
		a.halts = halts;
		return a;
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// present one event, hold until the beat is taken, then predict its answer
	task automatic send_event(event_t e, logic known, logic [1:0] hs, logic [6:0] tx);
		answer_t a;
		int g;
		s_tvalid <= 1'b1;
		s_tuser <= e.cmd;
		s_tdata <= {7'd0, e.tog, e.length, e.index, e.value, e.code, e.rtype};
		do @(posedge clk); while (!s_tready);
		a = answer_for(e);
		if (known) begin
			a.hs = hs;
			a.tx = tx;
		end
		answers_due.push_back(a);
		g = pick_gap();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write one register; the caller drops cfg_valid after the last write
	task automatic write_reg(int idx, logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx[2:0];
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == RegWakeup) wake_ok = val[0];
		else desc_len[idx] = val;
	endtask

	function automatic logic [15:0] rand_len();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 3));
			default: return 16'($urandom_range(0, 80));
		endcase
	endfunction

	// setup with random content, mostly well-formed
	function automatic event_t rand_setup();
		event_t e;
		logic [15:0] ep;
		e = '0;
		e.cmd = CmdSetup;
		e.rtype = RtStdDev;
		e.length = rand_len();
		e.value = 16'($urandom);
		e.index = 16'($urandom);
		ep = {8'd0, ($urandom_range(0, 1) ? 8'h80 : 8'h00) | 8'($urandom_range(0, 5))};
		case ($urandom_range(0, 13))
			0, 1, 2, 3: begin
				e.code = ReqGetDesc;
				e.value = {$urandom_range(0, 5) == 0 ? 8'($urandom) : 8'($urandom_range(1, 3)),
					8'($urandom_range(0, 5))};
			end
			4: begin e.code = ReqSetAddress; end
			5: begin e.code = ReqGetConfig; end
			6: begin e.code = ReqSetConfig; end
			7: begin e.code = ReqGetStatus; e.rtype = 8'($urandom_range(0, 2)); end
			8: begin e.code = $urandom_range(0, 1) ? ReqGetIface : ReqSetIface; end
			9, 10: begin
				e.code = $urandom_range(0, 1) ? ReqSetFeature : ReqClrFeature;
				e.rtype = $urandom_range(0, 3) ? RtStdEp : 8'($urandom_range(0, 3));
				if ($urandom_range(0, 3)) e.index = ep;
				if ($urandom_range(0, 3)) e.value = 16'($urandom_range(0, 1));
			end
			11: begin e.code = ReqSetLineCoding; e.rtype = RtClass; end
			12: begin
				e.code = $urandom_range(0, 1) ? ReqGetLineCoding : ReqSetCtrlLine;
				e.rtype = RtClass;
			end
			default: begin e.code = 8'($urandom); e.rtype = 8'($urandom); end
		endcase
		return e;
	endfunction

	task automatic random_run(int n);
		event_t e;
		int count, k;
		count = 0;
		while (count < n) begin
			if ($urandom_range(0, 19) == 0) begin
				// noise or bus reset
				e = 75'({$urandom, $urandom, $urandom});
				if ($urandom_range(0, 2) == 0) e.cmd = CmdBusReset;
				send_event(e, 0, 0, 0);
				count++;
			end else begin
				send_event(rand_setup(), 0, 0, 0);
				count++;
				k = $urandom_range(0, 6);
				repeat (k) begin
					e = 75'({$urandom, $urandom, $urandom});
					e.cmd = $urandom_range(0, 3) ? CmdIn : CmdOut;
					send_event(e, 0, 0, 0);
					count++;
				end
			end
		end
	endtask

	// answer sink: random backpressure unless no_idle is set, field-wise compare
	always @(posedge clk) begin
		answer_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (answers_due.size() == 0) begin
				$display("%0t: unexpected answer %h", $time, m_tdata);
				errors++;
			end else begin
				want = answers_due.pop_front();
				if (got !== want) begin
					errors++;
					if (got.hs !== want.hs)
						$display("%0t: handshake exp %0d got %0d", $time, want.hs, got.hs);
					if (got.tx !== want.tx)
						$display("%0t: tx_len exp %0d got %0d", $time, want.tx, got.tx);
					if (got.src !== want.src)
						$display("%0t: data_source exp %0d got %0d", $time, want.src, got.src);
					if (got.dsel !== want.dsel)
						$display("%0t: desc_select exp %0d got %0d", $time, want.dsel, got.dsel);
					if (got.off !== want.off)
						$display("%0t: desc_offset exp %0d got %0d", $time, want.off, got.off);
					if (got.cfg !== want.cfg)
						$display("%0t: config_value exp %0d got %0d", $time, want.cfg, got.cfg);
					if (got.addr !== want.addr)
						$display("%0t: device_address exp %0d got %0d", $time, want.addr,
							got.addr);
					if (got.halts !== want.halts)
						$display("%0t: endpoint_halts exp %h got %h", $time, want.halts,
							got.halts);
					if (got.ev !== want.ev)
						$display("%0t: class_event exp %0d got %0d", $time, want.ev, got.ev);
				end
			end
		end
		if (no_idle) begin
			m_tready <= 1'b1;
		end else if (rdy_hold > 0) begin
			rdy_hold--;
			m_tready <= 1'b0;
		end else begin
			case ($urandom_range(0, 19))
				0: rdy_hold = $urandom_range(15, 40);
				1, 2, 3: rdy_hold = $urandom_range(1, 3);
				default: ;
			endcase
			m_tready <= (rdy_hold == 0);
		end
	end

	initial begin
		row_t rows [] = '{
			'{'{CmdIn, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1, HsNak, 7'd0},
			'{'{CmdSetup, RtStdDev, ReqGetDesc, 16'h0100, 16'h0000, 16'h0040, 1'b0},
				1, HsAck, 7'd8},
			'{'{CmdIn, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1, HsAck, 7'd8},
			'{'{CmdIn, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1, HsAck, 7'd2},
			'{'{CmdIn, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}, 1, HsAck, 7'd0},
			'{'{CmdSetup, RtStdDev, ReqGetDesc, 16'h0209, 16'h0000, 16'h0005, 1'b0},
				1, HsAck, 7'd5},
			'{'{CmdSetup, RtStdDev, ReqGetDesc, 16'h0309, 16'h0000, 16'hFFFF, 1'b0},
				1, HsAck, 7'd0},
			'{'{CmdSetup, RtStdDev, ReqGetDesc, 16'h0400, 16'h0000, 16'h0040, 1'b0},
				1, HsStall, 7'd0},
			'{'{CmdSetup, RtVendor, ReqGetStatus, 16'h0000, 16'h0000, 16'h0002, 1'b0},
				1, HsStall, 7'd0},
			'{'{CmdSetup, RtReserved, ReqGetStatus, 16'h0000, 16'h0000, 16'h0002, 1'b0},
				1, HsStall, 7'd0},
			'{'{CmdSetup, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}, 1, HsStall, 7'd0},
			'{'{CmdIn, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1, HsNak, 7'd0},
			'{'{CmdSetup, RtClass, ReqGetLineCoding, 16'h0000, 16'h0000, 16'h0040, 1'b0},
				1, HsAck, 7'd7},
			'{'{CmdSetup, RtClass, ReqSetCtrlLine, 16'h0003, 16'h0000, 16'h0000, 1'b0},
				1, HsAck, 7'd0},
			'{'{CmdSetup, RtClass, ReqUnknown, 16'h0000, 16'h0000, 16'h0000, 1'b0},
				1, HsStall, 7'd0},
			'{'{CmdSetup, RtClass, ReqSetLineCoding, 16'h0000, 16'h0000, 16'h0007, 1'b0},
				1, HsAck, 7'd0},
			'{'{CmdOut, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1, HsNak, 7'd0},
			'{'{CmdOut, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1}, 1, HsAck, 7'd0},
			'{'{CmdSetup, RtStdDev, ReqGetStatus, 16'h0000, 16'h0000, 16'h0001, 1'b0},
				1, HsAck, 7'd1},
			'{'{CmdSetup, RtStdDev, ReqSetConfig, 16'hFFFF, 16'h0000, 16'h0000, 1'b0},
				0, HsAck, 7'd0},
			'{'{CmdSetup, RtStdDev, ReqGetConfig, 16'h0000, 16'h0000, 16'h0000, 1'b0},
				1, HsAck, 7'd0},
			'{'{CmdSetup, RtStdDev, ReqSetAddress, 16'h007F, 16'h0000, 16'h0000, 1'b0},
				0, HsAck, 7'd0},
			'{'{CmdIn, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 0, HsNak, 7'd0},
			'{'{CmdSetup, RtStdEp, ReqSetFeature, 16'h0000, 16'h0084, 16'h0000, 1'b0},
				0, HsAck, 7'd0},
			'{'{CmdSetup, RtStdEp, ReqSetFeature, 16'h0000, 16'h0184, 16'h0000, 1'b0},
				1, HsStall, 7'd0},
			'{'{CmdSetup, RtStdEp, ReqClrFeature, 16'h0005, 16'hFF84, 16'h0000, 1'b0},
				0, HsAck, 7'd0},
			'{'{CmdSetup, RtStdDev, ReqSetFeature, FeatWakeup, 16'h0000, 16'h0000, 1'b0},
				1, HsStall, 7'd0},
			'{'{CmdBusReset, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0},
				1, HsNak, 7'd0}
		};
		int p, i;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		desc_len = '{8'd18, 8'd67, 8'd4, 8'd0, 8'd0, 8'd0, 8'd0};
		wake_ok = 0;
		pend_req = NoRequest;
		remain = 0;
		cur_desc = NoDesc;
		cur_off = 0;
		pend_addr = 0;
		sel_cfg = 0;
		usb_addr = 0;
		halts = 0;
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[r])
			send_event(rows[r].ev, rows[r].known, rows[r].hs, rows[r].tx);
		random_run(250);

		// register phases: lengths all zero, all 254, then two random settings; wakeup off only in the third
		for (p = 0; p < 4; p++) begin
			drain();
			for (i = 0; i < NumRegs; i++) begin
				case (p)
					0: write_reg(i, (i == RegWakeup) ? 8'd1 : 8'd0);
					1: write_reg(i, (i == RegWakeup) ? 8'd1 : 8'd254);
					2: write_reg(i, (i == RegWakeup) ? 8'd0 : 8'($urandom_range(0, 254)));
					default: write_reg(i, (i == RegWakeup) ? 8'd1
						: 8'($urandom_range(0, 254)));
				endcase
			end
			cfg_valid <= 1'b0;
			no_idle = (p == 1);
			random_run(270);
		end

		drain();
		repeat (10) @(posedge clk);
		if (errors == 0 && answers_due.size() == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/uce_pkg.sv
rtl/core/uce_front.sv
rtl/core/uce_queue.sv
rtl/core/uce_back.sv
rtl/core/usb_control_endpoint_request_handler_core.sv
dv/testbench.sv
